// ===== design/mavn_pkg.sv =====
// Shared types for the max-abs vector normalizer.
// Status structs passed between the collector, the divider and the top level.
// No dependencies.
`default_nettype none

package mavn_pkg;

  typedef struct packed {
    logic go;
    logic zero_scale;
  } run_stat_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== design/max_abs_vector_normalizer.sv =====
// Top level of the max-abs vector normalizer: result sequencer and output register.
// Instantiates mavn_collect and mavn_divider; depends on mavn_pkg.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall    in_element_value
//   out_      output     out_valid / out_stall  index, normalized, scale, zero, last
//   cfg_      input      cfg_write_en           cfg_vector_length
//
// Elements are taken one per cycle until the vector is complete.
// The final element starts the result run: each element goes through a memory read,
// a divider load, FRACTION_BITS+1 serial divide steps and a handoff, using the one
// shared bit-serial divider; the input stalls for the whole run.
// Synchronous active-low reset; length resets to 1. A stalled result holds in
// the output register while the next division proceeds.
`default_nettype none

module max_abs_vector_normalizer #(
  parameter int MAX_LENGTH    = 16,
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_write_en,
  input  wire  [$clog2(MAX_LENGTH+1)-1:0]        cfg_vector_length,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire  signed [VALUE_WIDTH-1:0]          in_element_value,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic [$clog2(MAX_LENGTH)-1:0]          out_element_index,
  output logic signed [FRACTION_BITS+1:0]        out_normalized_value,
  output logic signed [VALUE_WIDTH-1:0]          out_scale_value,
  output logic                                   out_zero_scale,
  output logic                                   out_last_of_run
);

  localparam int IW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int NW = FRACTION_BITS + 2;
  localparam logic signed [NW-1:0] NORM_ONE = {2'b01, {FRACTION_BITS{1'b0}}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FETCH,
    ST_START,
    ST_DIV
  } state_t;

  state_t                   state_r;
  logic [IW-1:0]            k_r;
  logic                     out_valid_r;
  logic [IW-1:0]            out_index_r;
  logic signed [NW-1:0]     out_norm_r;
  logic [VALUE_WIDTH-1:0]   out_scale_r;
  logic                     out_zero_r;
  logic                     out_last_r;

  logic                     accept;
  logic                     div_start;
  logic                     out_free;
  logic                     out_load;
  logic                     last;
  logic [VALUE_WIDTH-1:0]   rd_data;
  logic [CW-1:0]            run_n;
  logic [VALUE_WIDTH-1:0]   scale;
  logic signed [NW-1:0]     quotient;
  mavn_pkg::run_stat_t      run;
  mavn_pkg::div_stat_t      div_stat;

  assign in_stall  = (state_r != ST_LOAD) || run.go;
  assign accept    = in_valid && !in_stall;
  assign div_start = (state_r == ST_START);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DIV) && !div_stat.busy && out_free;
  assign last      = (CW'(k_r) + CW'(1)) == run_n;

  mavn_collect #(
    .MAX_LENGTH  (MAX_LENGTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_collect (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_vector_length (cfg_vector_length),
    .accept            (accept),
    .in_value          (in_element_value),
    .rd_addr           (k_r),
    .rd_data           (rd_data),
    .run_n             (run_n),
    .scale             (scale),
    .run               (run)
  );

  mavn_divider #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (rd_data),
    .den      (scale),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (run.go) begin
            k_r     <= '0;
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_r <= ST_START;
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (out_load) begin
            out_index_r <= k_r;
            out_norm_r  <= run.zero_scale ? '0 : quotient;
            out_scale_r <= scale;
            out_zero_r  <= run.zero_scale;
            out_last_r  <= last;
            if (last) begin
              state_r <= ST_LOAD;
            end else begin
              k_r     <= k_r + IW'(1);
              state_r <= ST_FETCH;
            end
          end
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_element_index    = out_index_r;
  assign out_normalized_value = out_norm_r;
  assign out_scale_value      = out_scale_r;
  assign out_zero_scale       = out_zero_r;
  assign out_last_of_run      = out_last_r;

  a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_norm_r == '0)
    else $error("nonzero quotient on zero-scale transaction");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_norm_r <= NORM_ONE) && (out_norm_r >= -NORM_ONE))
    else $error("normalized value outside [-1, 1]");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_run_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    run.go |-> state_r == ST_LOAD)
    else $error("vector completed during a result run");

endmodule

`default_nettype wire

// ===== design/mavn_collect.sv =====
// Element collector: length register, element memory, running largest-magnitude element.
// Flags the end of a vector and holds its scale and element count.
// Depends on mavn_pkg.
`default_nettype none

module mavn_collect #(
  parameter int MAX_LENGTH  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_write_en,
  input  wire  [$clog2(MAX_LENGTH+1)-1:0]       cfg_vector_length,
  input  wire                                   accept,
  input  wire  [VALUE_WIDTH-1:0]                in_value,
  input  wire  [$clog2(MAX_LENGTH)-1:0]         rd_addr,
  output logic [VALUE_WIDTH-1:0]                rd_data,
  output logic [$clog2(MAX_LENGTH+1)-1:0]       run_n,
  output logic [VALUE_WIDTH-1:0]                scale,
  output mavn_pkg::run_stat_t                   run
);

  localparam int IW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);

  logic [VALUE_WIDTH-1:0] store_r [MAX_LENGTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [CW-1:0]          len_r;
  logic [CW-1:0]          loaded_r;
  logic [VALUE_WIDTH-1:0] largest_r;
  logic                   go_r;
  logic                   zero_r;
  logic [CW-1:0]          n_r;
  logic [VALUE_WIDTH-1:0] scale_r;

  logic [CW-1:0]          len_eff;
  logic [VALUE_WIDTH-1:0] mag_x;
  logic [VALUE_WIDTH-1:0] mag_l;
  logic                   take;
  logic [VALUE_WIDTH-1:0] largest_nxt;
  logic [CW-1:0]          loaded_nxt;
  logic                   done;

  always_comb begin
    if (len_r == '0) begin
      len_eff = CW'(1);
    end else if (len_r > CW'(MAX_LENGTH)) begin
      len_eff = CW'(MAX_LENGTH);
    end else begin
      len_eff = len_r;
    end
  end

  assign mag_x       = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
  assign mag_l       = largest_r[VALUE_WIDTH-1] ? (~largest_r + 1'b1) : largest_r;
  assign take        = (loaded_r == '0) || (mag_x > mag_l);
  assign largest_nxt = take ? in_value : largest_r;
  assign loaded_nxt  = loaded_r + CW'(1);
  assign done        = loaded_nxt >= len_eff;

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[loaded_r[IW-1:0]] <= in_value;
    end
    rd_data_r <= store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= CW'(1);
      loaded_r  <= '0;
      largest_r <= '0;
      go_r      <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (cfg_write_en) begin
        len_r <= cfg_vector_length;
      end
      if (accept) begin
        if (done) begin
          loaded_r  <= '0;
          largest_r <= '0;
          go_r      <= 1'b1;
        end else begin
          loaded_r  <= loaded_nxt;
          largest_r <= largest_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      scale_r <= largest_nxt;
      n_r     <= loaded_nxt;
      zero_r  <= (largest_nxt == '0);
    end
  end

  assign rd_data        = rd_data_r;
  assign run_n          = n_r;
  assign scale          = scale_r;
  assign run.go         = go_r;
  assign run.zero_scale = zero_r;

endmodule

`default_nettype wire

// ===== design/mavn_divider.sv =====
// Serial restoring divider: one quotient bit per cycle, signed result.
// Takes signed operands, divides magnitudes, applies the sign at the output.
// Depends on mavn_pkg.
`default_nettype none

module mavn_divider #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire  [VALUE_WIDTH-1:0]            num,
  input  wire  [VALUE_WIDTH-1:0]            den,
  output logic signed [FRACTION_BITS+1:0]   quotient,
  output mavn_pkg::div_stat_t               stat
);

  localparam int STEPS = FRACTION_BITS + 1;
  localparam int SW    = $clog2(STEPS + 1);

  logic [VALUE_WIDTH-1:0]   rem_r;
  logic [VALUE_WIDTH-1:0]   den_r;
  logic [FRACTION_BITS:0]   quo_r;
  logic                     neg_r;
  logic [SW-1:0]            cnt_r;
  logic                     busy_r;

  logic                     bit_nxt;
  logic [VALUE_WIDTH-1:0]   diff;
  logic [VALUE_WIDTH-1:0]   rem_nxt;

  assign bit_nxt = rem_r >= den_r;
  assign diff    = bit_nxt ? (rem_r - den_r) : rem_r;
  assign rem_nxt = {diff[VALUE_WIDTH-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= SW'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[VALUE_WIDTH-1] ? (~num + 1'b1) : num;
      den_r <= den[VALUE_WIDTH-1] ? (~den + 1'b1) : den;
      neg_r <= num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRACTION_BITS-1:0], bit_nxt};
    end
  end

  assign quotient  = neg_r ? ((~{1'b0, quo_r}) + 1'b1) : {1'b0, quo_r};
  assign stat.busy = busy_r;

endmodule

`default_nettype wire
